// ----- rtl/core/sorted_timer_event_queue_core_defines.svh -----
// ---------------------------------------------------------------------------
// sorted_timer_event_queue_core_defines
// Assertion macros for the sorted timer event queue core.
// ---------------------------------------------------------------------------
`ifndef SORTED_TIMER_EVENT_QUEUE_CORE_DEFINES_SVH
`define SORTED_TIMER_EVENT_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, clocked on clk, off during reset
`define STQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STQ_ASSERT_NOW(lbl, ante, cons, msg)
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/stq_pkg.sv -----
// ---------------------------------------------------------------------------
// stq_pkg
// Shared types and codes of the sorted timer event queue.
// ---------------------------------------------------------------------------
package stq_pkg;

    localparam int TIME_W  = 64;
    localparam int DELTA_W = 32;

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_ADV    = 2'd2;
    localparam logic [1:0] REQ_NEXT   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [TIME_W-1:0] key_time;
    } cell_cmd_t;

endpackage

// ----- rtl/core/sorted_timer_event_queue_core.sv -----
// ---------------------------------------------------------------------------
// sorted_timer_event_queue_core
// Timer queue kept sorted by expiry in a row of shifting slots.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Results come back
// on done, one cycle each, and cannot be held off. Add and remove pass
// through the capture state and one step in the slot row and return one
// result; the next request can follow at once. Advance and advance-to-next
// first move the time, then the row pops one due timer per cycle, each
// popped timer being one result. Advance-to-next on an empty queue reports
// empty from the execute state, like add. An advance that pops nothing
// returns one result with expired_valid low. current_time always shows the
// time after the request. On insert or remove only the slots from the insert
// point or the removed timer on move, while a pop shifts the whole row, so
// the slot count sets area and the depth of the remove search chain.
// ---------------------------------------------------------------------------
`include "sorted_timer_event_queue_core_defines.svh"

module sorted_timer_event_queue_core
    import stq_pkg::*;
#(
    parameter int TIMER_SLOTS = 16,
    parameter int ID_BITS     = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // request side
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               req_type,
    input  logic [ID_BITS-1:0]       timer_id,
    input  logic signed [TIME_W-1:0] expiry_time,
    input  logic [DELTA_W-1:0]       advance_delta,
    // result side
    output logic                     done,
    output logic [1:0]               status,
    output logic                     expired_valid,
    output logic [ID_BITS-1:0]       expired_id,
    output logic signed [TIME_W-1:0] current_time,
    output logic                     last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP
    } state_t;

    state_t                   state_reg;

    // captured request
    logic [1:0]               req_reg;
    logic [ID_BITS-1:0]       id_reg;
    logic signed [TIME_W-1:0] time_reg;
    logic [DELTA_W-1:0]       delta_reg;

    logic signed [TIME_W-1:0] now_reg;

    // result registers
    logic                     done_reg;
    logic [1:0]               status_reg;
    logic                     exp_valid_reg;
    logic [ID_BITS-1:0]       exp_id_reg;
    logic                     last_reg;

    // slot row wiring
    cell_cmd_t                cmd;
    logic                     valid_w  [TIMER_SLOTS];
    logic signed [TIME_W-1:0] expiry_w [TIMER_SLOTS];
    logic [ID_BITS-1:0]       id_w     [TIMER_SLOTS];
    logic                     ins_w    [TIMER_SLOTS];
    logic                     seen_w   [TIMER_SLOTS+1];

    logic                     full;
    logic                     found;
    logic                     head_due;
    logic                     next_due;

    assign seen_w[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < TIMER_SLOTS; g++)
        begin : g_cell
            logic                     l_ins;
            logic                     l_valid;
            logic signed [TIME_W-1:0] l_expiry;
            logic [ID_BITS-1:0]       l_id;
            logic                     r_valid;
            logic signed [TIME_W-1:0] r_expiry;
            logic [ID_BITS-1:0]       r_id;

            if (g == 0)
            begin : g_head
                assign l_ins    = 1'b0;
                assign l_valid  = 1'b0;
                assign l_expiry = '0;
                assign l_id     = '0;
            end
            else
            begin : g_body
                assign l_ins    = ins_w[g-1];
                assign l_valid  = valid_w[g-1];
                assign l_expiry = expiry_w[g-1];
                assign l_id     = id_w[g-1];
            end

            if (g == TIMER_SLOTS - 1)
            begin : g_tail
                assign r_valid  = 1'b0;
                assign r_expiry = '0;
                assign r_id     = '0;
            end
            else
            begin : g_mid
                assign r_valid  = valid_w[g+1];
                assign r_expiry = expiry_w[g+1];
                assign r_id     = id_w[g+1];
            end

            stq_cell #(
                .ID_W (ID_BITS)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .cmd          (cmd),
                .key_id       (id_reg),
                .left_ins     (l_ins),
                .left_valid   (l_valid),
                .left_expiry  (l_expiry),
                .left_id      (l_id),
                .right_valid  (r_valid),
                .right_expiry (r_expiry),
                .right_id     (r_id),
                .seen_in      (seen_w[g]),
                .valid        (valid_w[g]),
                .expiry       (expiry_w[g]),
                .id           (id_w[g]),
                .ins          (ins_w[g]),
                .seen_out     (seen_w[g+1])
            );
        end
    endgenerate

    assign full     = valid_w[TIMER_SLOTS-1];
    assign found    = seen_w[TIMER_SLOTS];
    // outside insert the key is the current time, so !ins means due
    assign head_due = !ins_w[0];
    assign next_due = !ins_w[1];

    // command to the whole row
    always_comb
    begin
        cmd.op       = CELL_HOLD;
        cmd.key_time = now_reg;
        case (state_reg)
            S_EXEC:
            begin
                case (req_reg)
                    REQ_ADD:
                    begin
                        cmd.key_time = time_reg;
                        cmd.op       = full ? CELL_HOLD : CELL_INSERT;
                    end
                    REQ_REMOVE:
                    begin
                        cmd.op = CELL_REMOVE;
                    end
                    default:
                    begin
                        cmd.op = CELL_HOLD;
                    end
                endcase
            end
            S_POP:
            begin
                cmd.op = head_due ? CELL_SHIFT : CELL_HOLD;
            end
            default:
            begin
                cmd.op = CELL_HOLD;
            end
        endcase
    end

    // captured request; payload only
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg   <= req_type;
            id_reg    <= timer_id;
            time_reg  <= expiry_time;
            delta_reg <= advance_delta;
        end
    end

    // sequencer, time and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            now_reg       <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_OK;
            exp_valid_reg <= 1'b0;
            exp_id_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    exp_valid_reg <= 1'b0;
                    exp_id_reg    <= '0;
                    last_reg      <= 1'b1;
                    status_reg    <= ST_OK;
                    case (req_reg)
                        REQ_ADD:
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= full ? ST_FULL : ST_OK;
                            state_reg  <= S_IDLE;
                        end
                        REQ_REMOVE:
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= found ? ST_OK : ST_NOTFOUND;
                            state_reg  <= S_IDLE;
                        end
                        REQ_ADV:
                        begin
                            // wraps modulo 2^64
                            now_reg   <= now_reg + $signed({{(TIME_W-DELTA_W){1'b0}},
                                                            delta_reg});
                            state_reg <= S_POP;
                        end
                        default:
                        begin
                            // advance to next: never moves time backwards
                            if (!valid_w[0])
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= ST_EMPTY;
                                state_reg  <= S_IDLE;
                            end
                            else
                            begin
                                if (ins_w[0])
                                begin
                                    now_reg <= expiry_w[0];
                                end
                                state_reg <= S_POP;
                            end
                        end
                    endcase
                end
                S_POP:
                begin
                    done_reg      <= 1'b1;
                    status_reg    <= ST_OK;
                    exp_valid_reg <= head_due;
                    exp_id_reg    <= head_due ? id_w[0] : '0;
                    last_reg      <= !(head_due && next_due);
                    if (!(head_due && next_due))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign expired_valid = exp_valid_reg;
    assign expired_id    = exp_id_reg;
    assign current_time  = now_reg;
    assign last          = last_reg;

    // more results of the same request must follow while still busy
    `STQ_ASSERT_NOW(a_more_while_busy, done && !last, busy,
        "non-final result while idle")
    // a taken request never yields a result in the very next cycle
    `STQ_ASSERT_NEXT(a_no_early_result, start && !busy, busy && !done,
        "result too early after request")
    // popped timers always report ok
    `STQ_ASSERT_NOW(a_pop_status_ok, done && expired_valid, status == ST_OK,
        "popped timer with error status")
    // empty report is a single, non-expiry result
    `STQ_ASSERT_NOW(a_empty_single, done && (status == ST_EMPTY),
        last && !expired_valid, "empty status with expiry or not final")

endmodule

// ----- rtl/core/stq_cell.sv -----
// ---------------------------------------------------------------------------
// stq_cell
// One slot of the sorted queue: holds a timer and moves it left or right.
// ---------------------------------------------------------------------------
module stq_cell
    import stq_pkg::*;
#(
    parameter int ID_W = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_cmd_t                cmd,
    input  logic [ID_W-1:0]          key_id,
    input  logic                     left_ins,
    input  logic                     left_valid,
    input  logic signed [TIME_W-1:0] left_expiry,
    input  logic [ID_W-1:0]          left_id,
    input  logic                     right_valid,
    input  logic signed [TIME_W-1:0] right_expiry,
    input  logic [ID_W-1:0]          right_id,
    input  logic                     seen_in,
    output logic                     valid,
    output logic signed [TIME_W-1:0] expiry,
    output logic [ID_W-1:0]          id,
    output logic                     ins,
    output logic                     seen_out
);

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [TIME_W-1:0] expiry_reg;
    logic signed [TIME_W-1:0] expiry_next;
    logic [ID_W-1:0]          id_reg;
    logic [ID_W-1:0]          id_next;
    logic                     match;

    // empty slot or later than key: key belongs at or before this slot
    assign ins      = !valid_reg || (expiry_reg > cmd.key_time);
    assign match    = valid_reg && (id_reg == key_id);
    assign seen_out = seen_in || match;

    always_comb
    begin
        valid_next  = valid_reg;
        expiry_next = expiry_reg;
        id_next     = id_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (ins && left_ins)
                begin
                    valid_next  = left_valid;
                    expiry_next = left_expiry;
                    id_next     = left_id;
                end
                else if (ins)
                begin
                    valid_next  = 1'b1;
                    expiry_next = cmd.key_time;
                    id_next     = key_id;
                end
            end
            CELL_REMOVE:
            begin
                if (seen_out)
                begin
                    valid_next  = right_valid;
                    expiry_next = right_expiry;
                    id_next     = right_id;
                end
            end
            CELL_SHIFT:
            begin
                valid_next  = right_valid;
                expiry_next = right_expiry;
                id_next     = right_id;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        expiry_reg <= expiry_next;
        id_reg     <= id_next;
    end

    assign valid  = valid_reg;
    assign expiry = expiry_reg;
    assign id     = id_reg;

endmodule
